// File: rtl/histogram_threshold_selector_defines.svh
// Assertion macros for the histogram threshold selector.
`ifndef HISTOGRAM_THRESHOLD_SELECTOR_DEFINES_SVH
`define HISTOGRAM_THRESHOLD_SELECTOR_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define HTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define HTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/hts_pkg.sv
// Shared types and constants of the histogram threshold selector.
`timescale 1ns / 1ps
package hts_pkg;
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_TOP   = 2'd2,
    OP_BOT   = 2'd3
  } op_t;

  localparam logic [1:0] CFG_BINS = 2'd0;
  localparam logic [1:0] CFG_LOW  = 2'd1;
  localparam logic [1:0] CFG_SPAN = 2'd2;
  localparam logic [1:0] CFG_FULL = 2'd3;

  localparam int DIV_STEPS = 33;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DIV,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_WALK,
    ST_THR,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clr_step;
    logic div_step;
    logic add_rd;
    logic add_wr;
    logic walk_step;
    logic thr_step;
    logic zero_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic walk_last;
    logic thr_last;
  } sts_t;
endpackage

// File: rtl/hts_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`timescale 1ns / 1ps
module hts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/hts_ctrl.sv
// Sequencer of the histogram threshold selector.
`timescale 1ns / 1ps
module hts_ctrl import hts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_op,
  input  sts_t       sts,
  output cmd_t       cmd,
  output logic       busy,
  output logic       done
);
  state_t state_r, state_nxt;
  op_t    op_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      // not a clear request: the reset clearing pass ends in idle, no result
      op_r    <= OP_ADD;
    end else begin
      state_r <= state_nxt;
      if (start && !busy) begin
        op_r <= op_t'(in_op);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (op_t'(in_op))
            OP_CLEAR: state_nxt = ST_CLEAR;
            OP_ADD:   state_nxt = ST_DIV;
            default:  state_nxt = ST_WALK;
          endcase
        end
      end
      ST_CLEAR:  if (sts.clr_last) state_nxt = (op_r == OP_CLEAR) ? ST_DONE : ST_IDLE;
      ST_DIV:    if (sts.div_last) state_nxt = ST_ADD_RD;
      ST_ADD_RD: state_nxt = ST_ADD_WR;
      ST_ADD_WR: state_nxt = ST_DONE;
      ST_WALK:   if (sts.walk_last) state_nxt = ST_THR;
      ST_THR:    if (sts.thr_last) state_nxt = ST_DONE;
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    done      = (state_r == ST_DONE);
    cmd.load  = (state_r == ST_IDLE) && start;
    case (state_r)
      ST_CLEAR:  cmd.clr_step  = 1'b1;
      ST_DIV:    cmd.div_step  = 1'b1;
      ST_ADD_RD: cmd.add_rd    = 1'b1;
      ST_ADD_WR: cmd.add_wr    = 1'b1;
      ST_WALK:   cmd.walk_step = 1'b1;
      ST_THR:    cmd.thr_step  = 1'b1;
      default:   cmd.zero_out  = (op_r == OP_CLEAR) || (op_r == OP_ADD);
    endcase
  end
endmodule

// File: rtl/hts_dp.sv
// Datapath: bin memory, serial divider, walk accumulator, threshold multiply.
`timescale 1ns / 1ps
module hts_dp import hts_pkg::*; #(
  parameter int MAX_BINS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] in_score,
  input  logic [15:0]        in_weight,
  input  logic [31:0]        in_target,
  input  logic               in_half_only,
  input  logic [6:0]         bins_in_use,
  input  logic signed [31:0] lowest_score,
  input  logic [30:0]        bin_span,
  input  logic               full_range,
  output logic [6:0]         out_boundary_bin,
  output logic [31:0]        out_selected_count,
  output logic signed [31:0] out_threshold_score
);
  localparam int AW = $clog2(MAX_BINS);
  localparam int PW = AW + 1;  // position / boundary width

  // effective bins and span
  logic [PW-1:0] nb;
  logic [30:0]   span;
  always_comb begin
    if (bins_in_use < 7'd2) nb = PW'(2);
    else if (32'(bins_in_use) > MAX_BINS) nb = PW'(MAX_BINS);
    else nb = PW'(bins_in_use);
    span = (bin_span == '0) ? 31'd1 : bin_span;
  end

  // request registers
  logic        top_r;
  logic [15:0] weight_r;
  logic [31:0] target_r;
  logic [PW-1:0] pos_r, lim_r;
  logic [33:0] sum_r;
  logic        stop_r;
  logic [5:0]  cnt_r;

  // divider: restoring, one quotient bit per step
  logic [32:0] dividend_r;
  logic [32:0] quot_r;
  logic [31:0] rem_r;
  logic [32:0] trial;
  assign trial = {rem_r, dividend_r[32]} - {2'b0, span};

  // exact score offset; negative offsets bin to zero
  logic signed [32:0] diff_c;
  assign diff_c = {in_score[31], in_score} - {lowest_score[31], lowest_score};

  // memory
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;
  hts_ram #(.WIDTH(32), .DEPTH(MAX_BINS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [PW-1:0] clr_ptr_r;
  logic [AW-1:0] idx_r;
  logic          rd_ok_r;  // walk read data valid

  // binning clamp
  logic [PW-1:0] idx_c;
  always_comb begin
    if (quot_r[32] || (quot_r[31:0] >= 32'(nb - PW'(1)))) idx_c = nb - PW'(1);
    else idx_c = quot_r[PW-1:0];
  end

  logic [32:0] addsum;
  assign addsum = {1'b0, rdata} + {17'b0, weight_r};

  // walk read address
  logic [PW-1:0] rd_pos;
  assign rd_pos = top_r ? pos_r - PW'(1) : pos_r;
  logic more;
  assign more = top_r ? (pos_r > lim_r) : (pos_r < lim_r);

  always_comb begin
    we    = 1'b0;
    waddr = clr_ptr_r[AW-1:0];
    wdata = '0;
    raddr = rd_pos[AW-1:0];
    if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.add_rd) begin
      raddr = idx_c[AW-1:0];
    end else if (cmd.add_wr) begin
      waddr = idx_r;
      we    = 1'b1;
      wdata = addsum[32] ? 32'hFFFF_FFFF : addsum[31:0];
    end
  end

  // threshold: lowest score plus boundary * span, the product as a shift-add over PW steps
  logic signed [63:0] thr_r;
  logic [PW-1:0]      bsh_r;
  logic [63:0]        span_sh_r;

  logic [33:0] nsum;
  assign nsum = sum_r + {2'b0, rdata};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ptr_r <= '0;
      rd_ok_r   <= 1'b0;
      stop_r    <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_ptr_r <= clr_ptr_r + PW'(1);
      if (cmd.load) begin
        clr_ptr_r <= '0;
        rd_ok_r   <= 1'b0;
        stop_r    <= 1'b0;
      end
      if (cmd.walk_step) begin
        if (!rd_ok_r) begin
          rd_ok_r <= 1'b1;
          stop_r  <= !more;
        end else if (!stop_r) begin
          if (nsum >= {2'b0, target_r}) begin
            stop_r <= 1'b1;
            if (sum_r == '0) begin
              sum_r <= nsum;
              pos_r <= top_r ? pos_r - PW'(1) : pos_r + PW'(1);
            end
          end else begin
            sum_r <= nsum;
            if (top_r) begin
              pos_r  <= pos_r - PW'(1);
              stop_r <= !(pos_r - PW'(1) > lim_r);
            end else begin
              pos_r  <= pos_r + PW'(1);
              stop_r <= !(pos_r + PW'(1) < lim_r);
            end
            rd_ok_r <= 1'b0;
          end
        end
      end
    end
    if (cmd.load) begin
      top_r      <= (op_t'(in_op) == OP_TOP);
      weight_r   <= in_weight;
      target_r   <= in_target;
      sum_r      <= '0;
      cnt_r      <= '0;
      quot_r     <= '0;
      rem_r      <= '0;
      dividend_r <= diff_c[32] ? 33'd0 : 33'(diff_c);
      if (op_t'(in_op) == OP_TOP) begin
        pos_r <= nb;
        lim_r <= (full_range && !in_half_only) ? '0 : (nb >> 1);
      end else begin
        pos_r <= '0;
        lim_r <= (full_range && !in_half_only) ? nb : (nb >> 1);
      end
    end
    if (cmd.div_step) begin
      cnt_r      <= cnt_r + 6'd1;
      dividend_r <= {dividend_r[31:0], 1'b0};
      if (!trial[32]) begin
        rem_r  <= trial[31:0];
        quot_r <= {quot_r[31:0], 1'b1};
      end else begin
        rem_r  <= {rem_r[30:0], dividend_r[32]};
        quot_r <= {quot_r[31:0], 1'b0};
      end
    end
    if (cmd.add_rd) idx_r <= idx_c[AW-1:0];
    if (cmd.walk_step && stop_r) begin
      bsh_r     <= pos_r;
      thr_r     <= 64'(lowest_score);
      span_sh_r <= {33'b0, span};
      cnt_r     <= '0;
    end
    if (cmd.thr_step) begin
      cnt_r     <= cnt_r + 6'd1;
      bsh_r     <= bsh_r >> 1;
      span_sh_r <= span_sh_r << 1;
      if (bsh_r[0]) thr_r <= thr_r + signed'(span_sh_r);
    end
  end

  assign sts.clr_last  = (clr_ptr_r == PW'(MAX_BINS - 1));
  assign sts.div_last  = (cnt_r == 6'(DIV_STEPS - 1));
  assign sts.walk_last = stop_r;
  assign sts.thr_last  = (cnt_r == 6'(PW - 1));

  always_comb begin
    if (cmd.zero_out) begin
      out_boundary_bin    = '0;
      out_selected_count  = '0;
      out_threshold_score = '0;
    end else begin
      out_boundary_bin    = 7'(pos_r);
      out_selected_count  = (sum_r[33:32] != 2'b0) ? 32'hFFFF_FFFF : sum_r[31:0];
      if (thr_r > 64'sd2147483647) out_threshold_score = 32'sh7FFF_FFFF;
      else if (thr_r < -64'sd2147483648) out_threshold_score = 32'sh8000_0000;
      else out_threshold_score = thr_r[31:0];
    end
  end
endmodule

// File: rtl/histogram_threshold_selector.sv
// Top level of the histogram threshold selector.
`timescale 1ns / 1ps
// Weighted score histogram with percentile threshold search.
// Request channel: raise start with in_op and the operands; a request is
// taken when start is high and busy is low. Operation codes: clear, add,
// select top, select bottom.
// Result channel: one result per request, shown for one cycle with
// out_valid high; the receiver cannot stall it and must take it.
// Operations: clear writes one memory row per cycle; add runs the 33-step
// serial divider, then a read-modify-write of the bin; select reads then
// accumulates per bin, then does a shift-add threshold multiply. The bin
// memory port sets the walk.
// One request at a time; the next may start the cycle after out_valid.
// Reset: configuration takes its reset values and a clearing pass zeroes
// all MAX_BINS bins; busy stays high during it.
// Configuration: cfg_we, cfg_index, cfg_wdata; write only while idle.
module histogram_threshold_selector import hts_pkg::*; #(
  parameter int MAX_BINS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] in_score,
  input  logic [15:0]        in_weight,
  input  logic [31:0]        in_target,
  input  logic               in_half_only,
  output logic               out_valid,
  output logic [6:0]         out_boundary_bin,
  output logic [31:0]        out_selected_count,
  output logic signed [31:0] out_threshold_score,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  logic [6:0]  bins_r;
  logic [31:0] low_r;
  logic [30:0] span_r;
  logic        full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_r <= 7'd64;
      low_r  <= '0;
      span_r <= 31'd65536;
      full_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BINS: bins_r <= cfg_wdata[6:0];
        CFG_LOW:  low_r  <= cfg_wdata;
        CFG_SPAN: span_r <= cfg_wdata[30:0];
        CFG_FULL: full_r <= cfg_wdata[0];
        default:  bins_r <= bins_r;
      endcase
    end
  end

  cmd_t cmd;
  sts_t sts;

  hts_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_op(in_op),
    .sts(sts), .cmd(cmd), .busy(busy), .done(out_valid)
  );

  hts_dp #(.MAX_BINS(MAX_BINS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_op(in_op), .in_score(in_score), .in_weight(in_weight),
    .in_target(in_target), .in_half_only(in_half_only),
    .bins_in_use(bins_r), .lowest_score(signed'(low_r)),
    .bin_span(span_r), .full_range(full_r),
    .out_boundary_bin(out_boundary_bin),
    .out_selected_count(out_selected_count),
    .out_threshold_score(out_threshold_score)
  );
endmodule

// File: rtl/hts_checker.sv
// Port-level assertions for the histogram threshold selector.
`timescale 1ns / 1ps
`include "histogram_threshold_selector_defines.svh"
module hts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [6:0] out_boundary_bin
);
  `HTS_ASSERT_IMPL(a_valid_busy, clk, rst_n, out_valid, busy)
  `HTS_ASSERT_NEXT(a_valid_pulse, clk, rst_n, out_valid, !out_valid)
  `HTS_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `HTS_ASSERT_IMPL(a_bin_range, clk, rst_n, out_valid, out_boundary_bin <= 7'd64)
endmodule

bind histogram_threshold_selector hts_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_boundary_bin(out_boundary_bin)
);

// File: verif/tb_histogram_threshold_selector.sv
// Testbench for the histogram threshold selector: random and directed requests checked
// against a behavioral predictor.
`timescale 1ns / 1ps
module tb_histogram_threshold_selector;
  import hts_pkg::*;

  localparam int NBINS = 64;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    op_t         op;
    logic [31:0] score;
    logic [15:0] weight;
    logic [31:0] target;
    logic        half_only;
  } req_t;

  typedef struct packed {
    logic [6:0]  boundary;
    logic [31:0] count;
    logic [31:0] thresh;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_op = '0;
  logic signed [31:0] in_score = '0;
  logic [15:0] in_weight = '0;
  logic [31:0] in_target = '0;
  logic in_half_only = 1'b0;
  logic out_valid;
  logic [6:0] out_boundary_bin;
  logic [31:0] out_selected_count;
  logic signed [31:0] out_threshold_score;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  histogram_threshold_selector #(.MAX_BINS(NBINS)) uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state: its own copy of the bins and registers
  logic [31:0] hist [NBINS];
  logic [6:0]  p_bins;
  logic [31:0] p_low;
  logic [30:0] p_span;
  logic        p_full;

  req_t pending_reqs[$];
  res_t expected_results[$];
  int   send_idle_pct = 0;
  int   errors = 0;
  int   cycles = 0;
  int   results_seen = 0;

  function automatic void queue_req(req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  function automatic res_t predict_request(req_t r);
    res_t   o;
    int     nb;
    int     lo_b;
    int     hi_b;
    int     pos;
    longint diff;
    longint span;
    longint idx;
    longint sum;
    longint t;
    longint c;
    logic [31:0] b;
    logic   whole;
    o = '0;
    nb = (p_bins < 2) ? 2 : ((p_bins > NBINS) ? NBINS : p_bins);
    span = (p_span == 0) ? 1 : longint'(p_span);
    whole = p_full && !r.half_only;
    sum = 0;
    if (r.op == OP_CLEAR) begin
      for (int i = 0; i < NBINS; i++) hist[i] = '0;
      return o;
    end
    if (r.op == OP_ADD) begin
      diff = longint'($signed(r.score)) - longint'($signed(p_low));
      idx = (diff > 0) ? diff / span : 0;
      if (idx > nb - 1) idx = nb - 1;
      c = longint'({32'd0, hist[idx]}) + r.weight;
      hist[idx] = (c > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : c[31:0];
      return o;
    end
    if (r.op == OP_TOP) begin
      lo_b = whole ? 0 : nb / 2;
      pos = nb;
      while (pos > lo_b) begin
        b = hist[pos - 1];
        sum += b;
        if (sum >= r.target) begin
          sum -= b;
          if (sum == 0) begin
            sum += b;
            pos--;
          end
          break;
        end
        pos--;
      end
    end else begin
      hi_b = whole ? nb : nb / 2;
      pos = 0;
      while (pos < hi_b) begin
        b = hist[pos];
        sum += b;
        if (sum >= r.target) begin
          sum -= b;
          if (sum == 0) begin
            sum += b;
            pos++;
          end
          break;
        end
        pos++;
      end
    end
    o.boundary = pos[6:0];
    o.count = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    t = longint'($signed(p_low)) + longint'(pos) * span;
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    o.thresh = t[31:0];
    return o;
  endfunction

  // driver: requests from the queue, random sender gaps
  always @(posedge clk) begin
    if (rst_n && !(start && busy)) begin
      if (start && !busy) begin
        // request taken this edge; predict on acceptance
        expected_results.insert(expected_results.size(),
                                predict_request(pending_reqs.pop_front()));
      end
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        start        <= 1'b1;
        in_op        <= pending_reqs[0].op;
        in_score     <= pending_reqs[0].score;
        in_weight    <= pending_reqs[0].weight;
        in_target    <= pending_reqs[0].target;
        in_half_only <= pending_reqs[0].half_only;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check each result against the oldest expectation
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected result bin=%0d", out_boundary_bin);
      end else begin
        res_t e;
        e = expected_results.pop_front();
        if (e.boundary !== out_boundary_bin || e.count !== out_selected_count ||
            e.thresh !== out_threshold_score) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("mismatch: exp bin=%0d cnt=%0d thr=%0d got bin=%0d cnt=%0d thr=%0d",
                     e.boundary, e.count, $signed(e.thresh), out_boundary_bin,
                     out_selected_count, out_threshold_score);
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BINS: p_bins = val[6:0];
      CFG_LOW:  p_low  = val;
      CFG_SPAN: p_span = val[30:0];
      default:  p_full = val[0];
    endcase
  endtask

  // wait until all queued requests are done, then let the block settle
  task automatic drain();
    while (pending_reqs.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic req_t rand_req();
    req_t r;
    r.op = op_t'($urandom_range(99) < 55 ? OP_ADD :
                 ($urandom_range(99) < 4 ? OP_CLEAR : $urandom_range(2, 3)));
    case ($urandom_range(3))
      0: r.score = $urandom;
      1: r.score = 32'(p_low + $urandom_range(0, 80) * (p_span == 0 ? 1 : p_span));
      default: r.score = 32'(p_low + $urandom_range(0, 32'h00FF_FFFF) - 32'h0001_0000);
    endcase
    r.weight = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom);
    case ($urandom_range(4))
      0: r.target = $urandom;
      1: r.target = '0;
      2: r.target = 32'hFFFF_FFFF;
      default: r.target = $urandom_range(0, 400000);
    endcase
    r.half_only = 1'($urandom);
    return r;
  endfunction

  function automatic req_t mk(op_t op, logic [31:0] s, logic [15:0] w,
                              logic [31:0] t, logic h);
    req_t r;
    r.op = op; r.score = s; r.weight = w; r.target = t; r.half_only = h;
    return r;
  endfunction

  initial begin
    for (int i = 0; i < NBINS; i++) hist[i] = '0;
    p_bins = 7'd64; p_low = '0; p_span = 31'd65536; p_full = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, every op, stop and no-reach cases
    queue_req(mk(OP_TOP, 0, 0, 0, 0));          // empty, target zero
    queue_req(mk(OP_ADD, 32'h8000_0000, 16'hFFFF, 0, 0)); // below range
    queue_req(mk(OP_ADD, 32'h7FFF_FFFF, 16'hFFFF, 0, 1)); // above range
    queue_req(mk(OP_ADD, 32'h0001_8000, 16'd5, 0, 0));
    queue_req(mk(OP_ADD, 32'h003E_0000, 16'd7, 0, 0));
    queue_req(mk(OP_TOP, 0, 0, 32'd1, 0));
    queue_req(mk(OP_TOP, 0, 0, 32'hFFFF_FFFF, 0));  // never reached
    queue_req(mk(OP_BOT, 0, 0, 32'd1, 0));
    queue_req(mk(OP_BOT, 0, 0, 32'd65540, 1));
    queue_req(mk(OP_BOT, 0, 0, 32'hFFFF_FFFF, 0));
    for (int i = 0; i < 3; i++) queue_req(mk(OP_TOP, 0, 0, 32'd3, 1));
    queue_req(mk(OP_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1));
    queue_req(mk(OP_BOT, 0, 0, 0, 0));
    drain();

    // one bin: eight full weights into it, then selections that never reach their target
    write_reg(CFG_FULL, 1);
    write_reg(CFG_BINS, 2);
    for (int i = 0; i < 8; i++) queue_req(mk(OP_ADD, 0, 16'hFFFF, 0, 0));
    queue_req(mk(OP_BOT, 0, 0, 32'hFFFF_FFFF, 0));
    queue_req(mk(OP_TOP, 0, 0, 32'hFFFF_FFFF, 0));
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin write_reg(CFG_BINS, 0); write_reg(CFG_SPAN, 0);
                 write_reg(CFG_LOW, 32'h8000_0000); end
        1: begin write_reg(CFG_BINS, 127); write_reg(CFG_SPAN, 32'h7FFF_FFFF);
                 write_reg(CFG_LOW, 32'h7FFF_FFFF); write_reg(CFG_FULL, 0); end
        2: begin write_reg(CFG_BINS, 64); write_reg(CFG_SPAN, 65536);
                 write_reg(CFG_LOW, 0); end
        3: begin write_reg(CFG_BINS, 1); write_reg(CFG_FULL, 1); end
        default: begin
          write_reg(CFG_BINS, $urandom_range(2, 64));
          write_reg(CFG_LOW, $urandom);
          write_reg(CFG_SPAN, $urandom_range(1, 32'h0010_0000));
          write_reg(CFG_FULL, $urandom);
        end
      endcase
      case (ph % 4)
        0: send_idle_pct = 0;
        1: send_idle_pct = 70;
        2: send_idle_pct = 17;
        default: send_idle_pct = 40;
      endcase
      for (int i = 0; i < 200; i++) queue_req(rand_req());
      drain();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// File: histogram_threshold_selector.f
+incdir+rtl
rtl/hts_pkg.sv
rtl/hts_ram.sv
rtl/hts_ctrl.sv
rtl/hts_dp.sv
rtl/histogram_threshold_selector.sv
rtl/hts_checker.sv
verif/tb_histogram_threshold_selector.sv
